// ===== rtl/core/obm_pkg.sv =====
// Shared types and constants for the order book batch matcher.
// Used by every module of the block; depends on nothing.
package obm_pkg;

    localparam int VALUE_W     = 48;
    localparam int PRODUCT_W   = 8;
    localparam int TIME_W      = 32;
    localparam int IN_DATA_W   = 144;
    localparam int OUT_DATA_W  = 104;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam int RES_CNT_W   = 5;

    localparam logic [RES_CNT_W-1:0] MAX_RESULTS = 5'd31;

    localparam logic [APB_ADDR_W-1:0] ADDR_PRODUCT = 3'd0;
    localparam logic [APB_ADDR_W-1:0] ADDR_TIME    = 3'd4;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_MATCH = 1'b1;
    localparam logic SIDE_ASK   = 1'b0;
    localparam logic SIDE_BID   = 1'b1;

    typedef struct packed {
        logic               is_match;
        logic               side;
        logic [VALUE_W-1:0] price;
        logic [VALUE_W-1:0] amount;
        logic               own;
    } t_cmd;

    typedef struct packed {
        logic               sale_valid;
        logic [VALUE_W-1:0] price;
        logic [VALUE_W-1:0] amount;
        logic               side;
        logic               own;
        logic               overflowed;
        logic               last;
    } t_result;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_WALK,
        BK_FINISH
    } t_bk_state;

endpackage

// ===== rtl/core/obm_front.sv =====
// Front end: input transaction accept, product and time filter, config registers.
// Depends on obm_pkg; feeds obm_queue.
module obm_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [obm_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    input  logic [0:0]                          s_axis_tuser,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [obm_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [obm_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [obm_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready,
    input  logic                                i_q_full,
    output logic                                o_push,
    output obm_pkg::t_cmd                       o_cmd
);

    logic [obm_pkg::PRODUCT_W-1:0] r_sel_product;
    logic [obm_pkg::TIME_W-1:0]    r_sel_time;
    logic                          wr_en;
    logic                          keep;
    logic [obm_pkg::PRODUCT_W-1:0] in_product;
    logic [obm_pkg::TIME_W-1:0]    in_time;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel_product <= '0;
            r_sel_time    <= '0;
        end else if (wr_en) begin
            if (paddr[2] == obm_pkg::ADDR_TIME[2]) begin
                r_sel_time <= pwdata;
            end else begin
                r_sel_product <= pwdata[obm_pkg::PRODUCT_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == obm_pkg::ADDR_TIME[2]) begin
            prdata = r_sel_time;
        end else begin
            prdata = {{(obm_pkg::APB_DATA_W-obm_pkg::PRODUCT_W){1'b0}}, r_sel_product};
        end
    end

    assign s_axis_tready = ~i_q_full;

    assign o_cmd.is_match = s_axis_tuser[0];
    assign o_cmd.side     = s_axis_tdata[0];
    assign o_cmd.price    = s_axis_tdata[48:1];
    assign o_cmd.amount   = s_axis_tdata[96:49];
    assign in_product     = s_axis_tdata[104:97];
    assign in_time        = s_axis_tdata[136:105];
    assign o_cmd.own      = s_axis_tdata[137];

    // drop loads for other products or time slots
    assign keep   = (s_axis_tuser[0] == obm_pkg::MODE_MATCH) ||
                    ((in_product == r_sel_product) && (in_time == r_sel_time));
    assign o_push = s_axis_tvalid & ~i_q_full & keep;

endmodule

// ===== rtl/core/obm_queue.sv =====
// Two-entry command queue between the front end and the book engine.
// Depends on obm_pkg.
module obm_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  obm_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output obm_pkg::t_cmd o_cmd
);

    obm_pkg::t_cmd r_mem [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== rtl/core/obm_book.sv =====
// Book engine: sorted insertion of orders and the match walk, with output register.
// Depends on obm_pkg; pops commands from obm_queue.
module obm_book #(
    parameter int SIDE_DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  obm_pkg::t_cmd     i_cmd,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output obm_pkg::t_result  o_res
);

    localparam int IW = $clog2(SIDE_DEPTH);
    localparam int CW = $clog2(SIDE_DEPTH + 1);
    localparam int VW = obm_pkg::VALUE_W;

    logic [VW-1:0] r_ask_p [SIDE_DEPTH];
    logic [VW-1:0] r_ask_a [SIDE_DEPTH];
    logic          r_ask_o [SIDE_DEPTH];
    logic [VW-1:0] r_bid_p [SIDE_DEPTH];
    logic [VW-1:0] r_bid_a [SIDE_DEPTH];
    logic          r_bid_o [SIDE_DEPTH];

    logic [CW-1:0] r_ask_cnt;
    logic [CW-1:0] r_bid_cnt;
    logic          r_ovf;
    logic [CW-1:0] r_a;
    logic [CW-1:0] r_b;
    logic [obm_pkg::RES_CNT_W-1:0] r_n;
    logic              r_pend_v;
    obm_pkg::t_result  r_pend;
    logic              r_out_v;
    obm_pkg::t_result  r_out;

    obm_pkg::t_bk_state r_state;
    obm_pkg::t_bk_state n_state;

    logic do_ins, do_start, do_sale, adv_a, adv_b, push_fin, out_can, load_out;
    logic [SIDE_DEPTH-1:0] keep_ask;
    logic [SIDE_DEPTH-1:0] keep_bid;
    logic [VW-1:0] ap, aa, bp, ba;
    logic          ao, bo;
    logic          a_done, b_done, hit, ends;
    obm_pkg::t_result new_sale;
    obm_pkg::t_result fin_res;

    assign ap = r_ask_p[r_a[IW-1:0]];
    assign aa = r_ask_a[r_a[IW-1:0]];
    assign ao = r_ask_o[r_a[IW-1:0]];
    assign bp = r_bid_p[r_b[IW-1:0]];
    assign ba = r_bid_a[r_b[IW-1:0]];
    assign bo = r_bid_o[r_b[IW-1:0]];

    assign a_done  = (r_a >= r_ask_cnt) || (r_n == obm_pkg::MAX_RESULTS);
    assign b_done  = (r_b >= r_bid_cnt);
    assign hit     = (bp >= ap) && (ba != '0);
    assign ends    = (ba >= aa);
    assign out_can = ~r_out_v | i_ready;

    always_comb begin
        new_sale.sale_valid = 1'b1;
        new_sale.price      = ap;
        new_sale.amount     = ends ? aa : ba;
        new_sale.side       = bo & ~ao;
        new_sale.own        = bo | ao;
        new_sale.overflowed = r_ovf;
        new_sale.last       = 1'b0;
    end

    always_comb begin
        if (r_pend_v) begin
            fin_res      = r_pend;
            fin_res.last = 1'b1;
        end else begin
            fin_res            = '0;
            fin_res.overflowed = r_ovf;
            fin_res.last       = 1'b1;
        end
    end

    always_comb begin
        for (int i = 0; i < SIDE_DEPTH; i++) begin
            keep_ask[i] = (CW'(i) < r_ask_cnt) && (r_ask_p[i] <= i_cmd.price);
            keep_bid[i] = (CW'(i) < r_bid_cnt) && (r_bid_p[i] >= i_cmd.price);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= obm_pkg::BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        o_pop    = 1'b0;
        do_ins   = 1'b0;
        do_start = 1'b0;
        do_sale  = 1'b0;
        adv_a    = 1'b0;
        adv_b    = 1'b0;
        push_fin = 1'b0;
        unique case (r_state)
            obm_pkg::BK_IDLE: begin
                if (i_q_valid) begin
                    o_pop = 1'b1;
                    if (i_cmd.is_match) begin
                        do_start = 1'b1;
                        n_state  = obm_pkg::BK_WALK;
                    end else begin
                        do_ins = 1'b1;
                    end
                end
            end
            obm_pkg::BK_WALK: begin
                if (a_done) begin
                    n_state = obm_pkg::BK_FINISH;
                end else if (b_done) begin
                    adv_a = 1'b1;
                end else if (!hit) begin
                    adv_b = 1'b1;
                end else if (!r_pend_v || out_can) begin
                    do_sale = 1'b1;
                    adv_a   = ends;
                    adv_b   = ~ends;
                end
            end
            obm_pkg::BK_FINISH: begin
                if (out_can) begin
                    push_fin = 1'b1;
                    n_state  = obm_pkg::BK_IDLE;
                end
            end
            default: n_state = obm_pkg::BK_IDLE;
        endcase
    end

    assign load_out = (do_sale & r_pend_v) | push_fin;

    // book contents
    always_ff @(posedge i_clk) begin
        if (do_ins && i_cmd.side == obm_pkg::SIDE_ASK && r_ask_cnt != CW'(SIDE_DEPTH)) begin
            for (int i = 0; i < SIDE_DEPTH; i++) begin
                if (!keep_ask[i]) begin
                    if (i == 0 || keep_ask[(i == 0) ? 0 : i-1]) begin
                        r_ask_p[i] <= i_cmd.price;
                        r_ask_a[i] <= i_cmd.amount;
                        r_ask_o[i] <= i_cmd.own;
                    end else begin
                        r_ask_p[i] <= r_ask_p[(i == 0) ? 0 : i-1];
                        r_ask_a[i] <= r_ask_a[(i == 0) ? 0 : i-1];
                        r_ask_o[i] <= r_ask_o[(i == 0) ? 0 : i-1];
                    end
                end
            end
        end else if (do_sale && !ends) begin
            r_ask_a[r_a[IW-1:0]] <= aa - ba;
        end
        if (do_ins && i_cmd.side == obm_pkg::SIDE_BID && r_bid_cnt != CW'(SIDE_DEPTH)) begin
            for (int i = 0; i < SIDE_DEPTH; i++) begin
                if (!keep_bid[i]) begin
                    if (i == 0 || keep_bid[(i == 0) ? 0 : i-1]) begin
                        r_bid_p[i] <= i_cmd.price;
                        r_bid_a[i] <= i_cmd.amount;
                        r_bid_o[i] <= i_cmd.own;
                    end else begin
                        r_bid_p[i] <= r_bid_p[(i == 0) ? 0 : i-1];
                        r_bid_a[i] <= r_bid_a[(i == 0) ? 0 : i-1];
                        r_bid_o[i] <= r_bid_o[(i == 0) ? 0 : i-1];
                    end
                end
            end
        end else if (do_sale) begin
            r_bid_a[r_b[IW-1:0]] <= ends ? (ba - aa) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out <= push_fin ? fin_res : r_pend;
        end
        if (do_sale) begin
            r_pend <= new_sale;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ask_cnt <= '0;
            r_bid_cnt <= '0;
            r_ovf     <= 1'b0;
            r_a       <= '0;
            r_b       <= '0;
            r_n       <= '0;
            r_pend_v  <= 1'b0;
            r_out_v   <= 1'b0;
        end else begin
            if (do_ins) begin
                if (i_cmd.side == obm_pkg::SIDE_ASK) begin
                    if (r_ask_cnt == CW'(SIDE_DEPTH)) begin
                        r_ovf <= 1'b1;
                    end else begin
                        r_ask_cnt <= r_ask_cnt + CW'(1);
                    end
                end else begin
                    if (r_bid_cnt == CW'(SIDE_DEPTH)) begin
                        r_ovf <= 1'b1;
                    end else begin
                        r_bid_cnt <= r_bid_cnt + CW'(1);
                    end
                end
            end
            if (do_start) begin
                r_a      <= '0;
                r_b      <= '0;
                r_n      <= '0;
                r_pend_v <= 1'b0;
            end
            if (adv_a) begin
                r_a <= r_a + CW'(1);
                r_b <= '0;
            end else if (adv_b) begin
                r_b <= r_b + CW'(1);
            end
            if (do_sale) begin
                r_pend_v <= 1'b1;
                r_n      <= r_n + obm_pkg::RES_CNT_W'(1);
            end
            if (push_fin) begin
                r_pend_v  <= 1'b0;
                r_ask_cnt <= '0;
                r_bid_cnt <= '0;
                r_ovf     <= 1'b0;
            end
            if (load_out) begin
                r_out_v <= 1'b1;
            end else if (i_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    assign o_valid = r_out_v;
    assign o_res   = r_out;

endmodule

// ===== rtl/core/order_book_batch_matcher.sv =====
// Order book batch matcher: price priority matching of a batch of limit orders.
// A front end filters and queues input transactions; the book engine inserts
// orders in sorted order and walks asks against bids on a match transaction.
// Slave stream: one transaction per order (tuser 0) or a match request (tuser 1).
// Master stream: sale results; tlast marks the final result of a match, and a
// match with no sale gives one result with tuser (sale valid) low.
// APB port: selected product at 0x0, selected time slot at 0x4.
// Loads: the queue takes a transaction every cycle while it has room; the book
// engine, while idle, pops and inserts one order per cycle from the queue.
// Match: the book engine visits (ask, bid) pairs in order, moving to the next
// ask when its bids run out; each sale is held until the next sale or the end
// of the walk, then leaves through the output register; at most 31 results.
// The book engine works on one transaction at a time.
// Reset clears counts, the overflow flag, queue and output valid flag; book
// entries need no clearing. A stalled receiver holds the output register and stops
// the walk at a sale while a sale is held; the queue keeps taking input until full.
module order_book_batch_matcher #(
    parameter int SIDE_DEPTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // side[0], price[48:1], amount[96:49], product[104:97], time[136:105], own[137]
    input  logic [obm_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // mode[0]
    input  logic [0:0]                          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // price[47:0], amount[95:48], side[96], own_sale[97], overflowed[98]
    output logic [obm_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    // sale_valid[0]
    output logic [0:0]                          m_axis_tuser,
    output logic                                m_axis_tlast,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [obm_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [obm_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [obm_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready
);

    logic             q_full, push, pop, q_valid;
    obm_pkg::t_cmd    f_cmd, q_cmd;
    obm_pkg::t_result res;

    obm_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_cmd         (f_cmd)
    );

    obm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (f_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    obm_book #(
        .SIDE_DEPTH (SIDE_DEPTH)
    ) u_book (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_cmd     (q_cmd),
        .o_pop     (pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_res     (res)
    );

    assign m_axis_tdata = {5'b0, res.overflowed, res.own, res.side, res.amount, res.price};
    assign m_axis_tuser = res.sale_valid;
    assign m_axis_tlast = res.last;

endmodule
